// ----- design/sbdr_pkg.sv -----
package sbdr_pkg;

    // Default sizes for the top-level parameters.
    localparam int MAX_SECTORS_DEF      = 4096;
    localparam int BLOCK_INDEX_BITS_DEF = 20;

    // Fixed field widths of the channel words.
    localparam int IDX_FIELD_W = 20;
    localparam int BYTE_W      = 8;
    localparam int START_W     = 41;
    localparam int LEN_W       = 22;

    // One bitmap bit covers a 512-byte sector.
    localparam int SECTOR_SHIFT = 9;
    localparam int BASE_W       = START_W - SECTOR_SHIFT;

    // Eight bit lanes plus one lane for the position after the last bit.
    localparam int LANES     = BYTE_W;
    localparam int POSITIONS = LANES + 1;

    // One word yields at most four closed runs plus one block-end range.
    localparam int MAX_RANGES = 5;
    localparam int RNG_CNT_W  = 3;

    // Configuration port.
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 13;
    localparam int MIN_SECTORS = 8;
    localparam logic [CFG_DATA_W-1:0] SPB_RESET = CFG_DATA_W'(4096);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SECTORS_PER_BLOCK = 2'd0,
        CFG_ROUGH_MODE        = 2'd1
    } t_cfg_reg;

endpackage

// ----- design/sbdr_item_if.sv -----
interface sbdr_item_if;
    logic                               valid;
    logic                               ready;
    logic [sbdr_pkg::IDX_FIELD_W-1:0]   block_index;
    logic [sbdr_pkg::BYTE_W-1:0]        bitmap_byte;

    modport source (output valid, block_index, bitmap_byte, input ready);
    modport sink   (input valid, block_index, bitmap_byte, output ready);
endinterface

// ----- design/sbdr_range_if.sv -----
interface sbdr_range_if;
    logic                               valid;
    logic                               ready;
    logic [sbdr_pkg::START_W-1:0]       range_start;
    logic [sbdr_pkg::LEN_W-1:0]         range_length;
    logic                               last_range;

    modport source (output valid, range_start, range_length, last_range, input ready);
    modport sink   (input valid, range_start, range_length, last_range, output ready);
endinterface

// ----- design/sbdr_lane.sv -----
module sbdr_lane #(
    parameter int LANE  = 0,
    parameter int SEC_W = 13,
    parameter int POS_W = 12
) (
    input  logic [SEC_W-1:0]            i_cnt,
    input  logic [SEC_W-1:0]            i_eff,
    input  logic                        i_in_run,
    input  logic [POS_W-1:0]            i_run_first,
    input  logic [sbdr_pkg::BYTE_W-1:0] i_bits,
    output logic                        o_active,
    output logic                        o_open,
    output logic                        o_close,
    output logic [POS_W-1:0]            o_start,
    output logic [SEC_W-1:0]            o_len
);

    logic [sbdr_pkg::BYTE_W:0] bits9;
    logic                      all_set;
    logic [3:0]                off;
    logic [SEC_W-1:0]          pos;

    assign bits9 = {1'b0, i_bits};
    assign pos   = i_cnt + SEC_W'(LANE);

    // The sector at this position exists only while it is below the block size.
    assign o_active = ({1'b0, i_cnt} + (SEC_W+1)'(LANE)) < {1'b0, i_eff};

    // Walk down from this position to find where the run ending here began.
    always_comb begin
        all_set = 1'b1;
        off     = 4'(LANE);
        o_open  = i_in_run;
        for (int j = sbdr_pkg::LANES - 1; j >= 0; j--) begin
            if (j < LANE) begin
                if (j == LANE - 1) begin
                    o_open = bits9[j];
                end
                if (all_set && bits9[j]) begin
                    off = 4'(j);
                end else begin
                    all_set = 1'b0;
                end
            end
        end
    end

    // A run reaching back past the word started in an earlier word.
    assign o_start = (all_set && i_in_run) ? i_run_first : POS_W'(i_cnt + SEC_W'(off));
    assign o_len   = pos - SEC_W'(o_start);

    // A clear bit right after a set one closes a run.
    assign o_close = (LANE < sbdr_pkg::LANES) && o_active && !bits9[LANE] && o_open;

endmodule

// ----- design/sbdr_merge.sv -----
module sbdr_merge #(
    parameter int SEC_W = 13,
    parameter int POS_W = 12,
    parameter int IDX_W = 20
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_fire,
    input  logic                                i_take,
    input  logic                                i_rough,
    input  logic [IDX_W-1:0]                    i_idx,
    input  logic [sbdr_pkg::BYTE_W-1:0]         i_bits,
    input  logic [SEC_W-1:0]                    i_cnt,
    input  logic [POS_W-1:0]                    i_hd,
    input  logic [sbdr_pkg::POSITIONS-1:0]      i_active,
    input  logic [sbdr_pkg::POSITIONS-1:0]      i_open,
    input  logic [sbdr_pkg::POSITIONS-1:0]      i_close,
    input  logic [POS_W-1:0]                    i_start [sbdr_pkg::POSITIONS],
    input  logic [SEC_W-1:0]                    i_len   [sbdr_pkg::POSITIONS],
    output logic                                o_in_run,
    output logic [POS_W-1:0]                    o_run_first,
    output logic [SEC_W-1:0]                    o_cnt,
    output logic [POS_W-1:0]                    o_hd,
    output logic                                o_a_valid,
    output logic [sbdr_pkg::RNG_CNT_W-1:0]      o_a_n,
    output logic [IDX_W-1:0]                    o_a_idx,
    output logic [POS_W-1:0]                    o_a_first [sbdr_pkg::MAX_RANGES],
    output logic [SEC_W-1:0]                    o_a_nsect [sbdr_pkg::MAX_RANGES]
);

    localparam int POS_SEL_W = $clog2(sbdr_pkg::POSITIONS);

    logic                           r_in_run, n_in_run;
    logic [POS_W-1:0]               r_run_first, n_run_first;
    logic [SEC_W-1:0]               r_cnt, n_cnt;
    logic [POS_W-1:0]               r_hd, n_hd;
    logic                           r_a_valid;
    logic [sbdr_pkg::RNG_CNT_W-1:0] r_a_n, n_a_n;
    logic [IDX_W-1:0]               r_a_idx;
    logic [POS_W-1:0]               r_a_first [sbdr_pkg::MAX_RANGES];
    logic [SEC_W-1:0]               r_a_nsect [sbdr_pkg::MAX_RANGES];
    logic [POS_W-1:0]               n_a_first [sbdr_pkg::MAX_RANGES];
    logic [SEC_W-1:0]               n_a_nsect [sbdr_pkg::MAX_RANGES];

    logic                           end_blk;
    logic [POS_SEL_W-1:0]           e_pos;
    logic                           e_open;
    logic [POS_W-1:0]               e_start;
    logic [SEC_W-1:0]               e_len;
    logic [POS_W-1:0]               hd_new;

    // The block ends unless the position after the last bit still lies inside it.
    assign end_blk = !i_active[sbdr_pkg::LANES];

    // Active lanes form a prefix, so their count is where the block stops in this word.
    always_comb begin
        e_pos = '0;
        for (int b = 0; b < sbdr_pkg::LANES; b++) begin
            e_pos = e_pos + POS_SEL_W'(i_active[b]);
        end
    end

    // Run state at the stop position, used for the block-end flush.
    always_comb begin
        e_open  = 1'b0;
        e_start = '0;
        e_len   = '0;
        for (int p = 0; p < sbdr_pkg::POSITIONS; p++) begin
            if (POS_SEL_W'(p) == e_pos) begin
                e_open  = i_open[p];
                e_start = i_start[p];
                e_len   = i_len[p];
            end
        end
    end

    // Highest dirty sector after this word.
    always_comb begin
        hd_new = i_hd;
        for (int b = 0; b < sbdr_pkg::LANES; b++) begin
            if (i_active[b] && i_bits[b]) begin
                hd_new = POS_W'(i_cnt + SEC_W'(b));
            end
        end
    end

    // Pack closed runs in sector order (exact mode only), then the block-end range.
    always_comb begin
        n_a_n = '0;
        for (int k = 0; k < sbdr_pkg::MAX_RANGES; k++) begin
            n_a_first[k] = '0;
            n_a_nsect[k] = '0;
        end
        if (!i_rough) begin
            for (int b = 0; b < sbdr_pkg::LANES; b++) begin
                if (i_close[b]) begin
                    n_a_first[n_a_n] = i_start[b];
                    n_a_nsect[n_a_n] = i_len[b];
                    n_a_n            = n_a_n + 1'b1;
                end
            end
        end
        if (end_blk) begin
            if (i_rough) begin
                n_a_first[n_a_n] = '0;
                n_a_nsect[n_a_n] = SEC_W'(hd_new) + 1'b1;
                n_a_n            = n_a_n + 1'b1;
            end else if (e_open) begin
                n_a_first[n_a_n] = e_start;
                n_a_nsect[n_a_n] = e_len;
                n_a_n            = n_a_n + 1'b1;
            end
        end
    end

    // Block state after this word.
    always_comb begin
        if (end_blk) begin
            n_cnt       = '0;
            n_in_run    = 1'b0;
            n_run_first = '0;
            n_hd        = '0;
        end else begin
            n_cnt       = i_cnt + SEC_W'(sbdr_pkg::LANES);
            n_in_run    = i_open[sbdr_pkg::LANES];
            n_run_first = i_open[sbdr_pkg::LANES] ? i_start[sbdr_pkg::LANES] : r_run_first;
            n_hd        = hd_new;
        end
    end

    // Block state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_in_run    <= 1'b0;
            r_run_first <= '0;
            r_hd        <= '0;
        end else if (i_fire) begin
            r_cnt       <= n_cnt;
            r_in_run    <= n_in_run;
            r_run_first <= n_run_first;
            r_hd        <= n_hd;
        end
    end

    // Merged ranges of the accepted word wait here for the emitter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (i_fire) begin
            r_a_valid <= 1'b1;
        end else if (i_take) begin
            r_a_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            r_a_n     <= n_a_n;
            r_a_idx   <= i_idx;
            r_a_first <= n_a_first;
            r_a_nsect <= n_a_nsect;
        end
    end

    assign o_in_run    = r_in_run;
    assign o_run_first = r_run_first;
    assign o_cnt       = r_cnt;
    assign o_hd        = r_hd;
    assign o_a_valid   = r_a_valid;
    assign o_a_n       = r_a_n;
    assign o_a_idx     = r_a_idx;
    assign o_a_first   = r_a_first;
    assign o_a_nsect   = r_a_nsect;

endmodule

// ----- design/sbdr_emit.sv -----
module sbdr_emit #(
    parameter int SEC_W = 13,
    parameter int POS_W = 12,
    parameter int IDX_W = 20
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic [SEC_W-1:0]                    i_eff,
    input  logic                                i_a_valid,
    input  logic [sbdr_pkg::RNG_CNT_W-1:0]      i_a_n,
    input  logic [IDX_W-1:0]                    i_a_idx,
    input  logic [POS_W-1:0]                    i_a_first [sbdr_pkg::MAX_RANGES],
    input  logic [SEC_W-1:0]                    i_a_nsect [sbdr_pkg::MAX_RANGES],
    output logic                                o_free,
    sbdr_range_if.source                        o_range
);

    localparam int PROD_W = IDX_W + SEC_W;

    logic                           r_b_valid;
    logic [sbdr_pkg::RNG_CNT_W-1:0] r_b_n;
    logic [sbdr_pkg::RNG_CNT_W-1:0] r_b_k;
    logic [sbdr_pkg::BASE_W-1:0]    r_b_base;
    logic [POS_W-1:0]               r_b_first [sbdr_pkg::MAX_RANGES];
    logic [SEC_W-1:0]               r_b_nsect [sbdr_pkg::MAX_RANGES];

    logic                           r_o_valid;
    logic [sbdr_pkg::START_W-1:0]   r_o_start;
    logic [sbdr_pkg::LEN_W-1:0]     r_o_len;
    logic                           r_o_last;

    logic [PROD_W-1:0]              prod;
    logic                           out_free;
    logic                           emit;
    logic                           last;
    logic                           b_free;
    logic [sbdr_pkg::BASE_W-1:0]    sum;
    logic [POS_W-1:0]               cur_first;
    logic [SEC_W-1:0]               cur_nsect;

    // Block offset in sectors; the byte offset keeps only the bits below 2^41.
    assign prod = PROD_W'(i_a_idx) * PROD_W'(i_eff);

    // Serializer control: one range per cycle into the output register while it is free.
    assign out_free = !r_o_valid || o_range.ready;
    assign emit     = r_b_valid && (r_b_n != '0) && out_free;
    assign last     = r_b_k == (r_b_n - 1'b1);
    assign b_free   = !r_b_valid || (r_b_n == '0) || (emit && last);
    assign o_free   = b_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
            r_b_k     <= '0;
        end else if (b_free) begin
            r_b_valid <= i_a_valid;
            r_b_k     <= '0;
        end else if (emit) begin
            r_b_k     <= r_b_k + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_free && i_a_valid) begin
            r_b_n     <= i_a_n;
            r_b_base  <= sbdr_pkg::BASE_W'(prod);
            r_b_first <= i_a_first;
            r_b_nsect <= i_a_nsect;
        end
    end

    // Current range: sector offsets scaled to bytes.
    assign cur_first = r_b_first[r_b_k];
    assign cur_nsect = r_b_nsect[r_b_k];
    assign sum       = r_b_base + sbdr_pkg::BASE_W'(cur_first);

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (emit) begin
            r_o_valid <= 1'b1;
        end else if (o_range.ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_o_start <= {sum, {sbdr_pkg::SECTOR_SHIFT{1'b0}}};
            r_o_len   <= sbdr_pkg::LEN_W'({cur_nsect, {sbdr_pkg::SECTOR_SHIFT{1'b0}}});
            r_o_last  <= last;
        end
    end

    assign o_range.valid        = r_o_valid;
    assign o_range.range_start  = r_o_start;
    assign o_range.range_length = r_o_len;
    assign o_range.last_range   = r_o_last;

endmodule

// ----- design/sector_bitmap_dirty_ranges_core.sv -----
// Channel   Dir  Word
// i_item    in   block_index, bitmap_byte
// o_range   out  range_start, range_length, last_range
// i_cfg_*   in   register index, write data (no read-back)
//
// One bitmap word is taken per cycle while the merge register can take it; eight bit
// lanes and a merge stage handle it. A word that yields n ranges (n is 0 to 5) keeps
// the serializer busy until all are out; the next word waits in the merge register.
// An accepted word passes the merge, serializer and output registers in turn.
// Reset is synchronous and active low; it clears the block state and the valids and reloads the config registers.
// Stalls on o_range fill the output register, serializer and merge register in turn.
module sector_bitmap_dirty_ranges_core #(
    parameter int MAX_SECTORS_PER_BLOCK = sbdr_pkg::MAX_SECTORS_DEF,
    parameter int BLOCK_INDEX_BITS      = sbdr_pkg::BLOCK_INDEX_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [sbdr_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [sbdr_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    sbdr_item_if.sink                           i_item,
    sbdr_range_if.source                        o_range
);

    localparam int SEC_W = $clog2(MAX_SECTORS_PER_BLOCK + 1);
    localparam int POS_W = $clog2(MAX_SECTORS_PER_BLOCK);
    localparam int IDX_W = (BLOCK_INDEX_BITS < sbdr_pkg::IDX_FIELD_W) ?
                           BLOCK_INDEX_BITS : sbdr_pkg::IDX_FIELD_W;

    logic [sbdr_pkg::CFG_DATA_W-1:0]    r_spb;
    logic                               r_rough;
    logic [SEC_W-1:0]                   eff;

    logic                               fire;
    logic                               b_free;
    logic                               in_run;
    logic [POS_W-1:0]                   run_first;
    logic [SEC_W-1:0]                   cnt;
    logic [POS_W-1:0]                   hd;

    logic [sbdr_pkg::POSITIONS-1:0]     active;
    logic [sbdr_pkg::POSITIONS-1:0]     open;
    logic [sbdr_pkg::POSITIONS-1:0]     close;
    logic [POS_W-1:0]                   start [sbdr_pkg::POSITIONS];
    logic [SEC_W-1:0]                   len   [sbdr_pkg::POSITIONS];

    logic                               a_valid;
    logic [sbdr_pkg::RNG_CNT_W-1:0]     a_n;
    logic [IDX_W-1:0]                   a_idx;
    logic [POS_W-1:0]                   a_first [sbdr_pkg::MAX_RANGES];
    logic [SEC_W-1:0]                   a_nsect [sbdr_pkg::MAX_RANGES];

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spb   <= sbdr_pkg::SPB_RESET;
            r_rough <= 1'b0;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == sbdr_pkg::CFG_SECTORS_PER_BLOCK) begin
                r_spb <= i_cfg_data;
            end else if (i_cfg_idx == sbdr_pkg::CFG_ROUGH_MODE) begin
                r_rough <= i_cfg_data[0];
            end
        end
    end

    // Block size clamped to the supported range.
    always_comb begin
        priority if (r_spb < sbdr_pkg::CFG_DATA_W'(sbdr_pkg::MIN_SECTORS)) begin
            eff = SEC_W'(sbdr_pkg::MIN_SECTORS);
        end else if (r_spb > sbdr_pkg::CFG_DATA_W'(MAX_SECTORS_PER_BLOCK)) begin
            eff = SEC_W'(MAX_SECTORS_PER_BLOCK);
        end else begin
            eff = SEC_W'(r_spb);
        end
    end

    // A word is taken whenever the merge register is empty or drains this cycle.
    assign i_item.ready = !a_valid || b_free;
    assign fire         = i_item.valid && i_item.ready;

    // One lane per bit position, plus one for the position after the word.
    for (genvar g = 0; g < sbdr_pkg::POSITIONS; g++) begin : g_lane
        sbdr_lane #(
            .LANE  (g),
            .SEC_W (SEC_W),
            .POS_W (POS_W)
        ) u_lane (
            .i_cnt       (cnt),
            .i_eff       (eff),
            .i_in_run    (in_run),
            .i_run_first (run_first),
            .i_bits      (i_item.bitmap_byte),
            .o_active    (active[g]),
            .o_open      (open[g]),
            .o_close     (close[g]),
            .o_start     (start[g]),
            .o_len       (len[g])
        );
    end

    sbdr_merge #(
        .SEC_W (SEC_W),
        .POS_W (POS_W),
        .IDX_W (IDX_W)
    ) u_merge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire),
        .i_take      (b_free),
        .i_rough     (r_rough),
        .i_idx       (i_item.block_index[IDX_W-1:0]),
        .i_bits      (i_item.bitmap_byte),
        .i_cnt       (cnt),
        .i_hd        (hd),
        .i_active    (active),
        .i_open      (open),
        .i_close     (close),
        .i_start     (start),
        .i_len       (len),
        .o_in_run    (in_run),
        .o_run_first (run_first),
        .o_cnt       (cnt),
        .o_hd        (hd),
        .o_a_valid   (a_valid),
        .o_a_n       (a_n),
        .o_a_idx     (a_idx),
        .o_a_first   (a_first),
        .o_a_nsect   (a_nsect)
    );

    sbdr_emit #(
        .SEC_W (SEC_W),
        .POS_W (POS_W),
        .IDX_W (IDX_W)
    ) u_emit (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_eff     (eff),
        .i_a_valid (a_valid),
        .i_a_n     (a_n),
        .i_a_idx   (a_idx),
        .i_a_first (a_first),
        .i_a_nsect (a_nsect),
        .o_free    (b_free),
        .o_range   (o_range)
    );

endmodule

// ----- dv/tb_top.sv -----
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import sbdr_pkg::*;

    localparam int SEC_IDX_W     = $clog2(MAX_SECTORS_DEF);
    localparam int RESET_CYCLES  = 11;
    localparam int SETTLE_CYCLES = 8;
    localparam int QUIET_LIMIT   = 2000;
    localparam int PHASES        = 8;
    localparam int PHASE_WORDS   = 4;
    localparam int BIG_EXACT     = 500;
    localparam int BIG_ROUGH     = 12;
    localparam logic [63:0] IDX_MASK = (64'd1 << BLOCK_INDEX_BITS_DEF) - 64'd1;

    // Register indexes past the end of the register list; writes to them are dropped.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = CFG_IDX_W'(3);
    localparam logic [CFG_DATA_W-1:0] SPB_ABOVE_MAX = '1;

    typedef enum {IDLE_NONE, IDLE_SRC, IDLE_SINK, IDLE_BOTH} t_idle;

    typedef struct packed {
        logic [IDX_FIELD_W-1:0] block_index;
        logic [BYTE_W-1:0]      bits;
    } t_bitmap_word;

    typedef struct packed {
        logic [START_W-1:0] start;
        logic [LEN_W-1:0]   length;
        logic               last;
    } t_range;

    logic                  i_clk    = 1'b0;
    logic                  i_rst_n  = 1'b0;
    logic                  cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx  = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    sbdr_item_if  item_ch ();
    sbdr_range_if range_ch ();

    sector_bitmap_dirty_ranges_core u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_item     (item_ch),
        .o_range    (range_ch)
    );

    // Words waiting to be driven and ranges waiting to come out.
    t_bitmap_word bitmap_words_q[$];
    t_range       dirty_ranges_q[$];

    // Register copies and block tracking state of the predictor.
    logic [CFG_DATA_W-1:0] spb_reg   = SPB_RESET;
    logic                  rough_reg = 1'b0;
    logic [CFG_DATA_W-1:0] sec_seen  = '0;
    logic                  run_open  = 1'b0;
    logic [SEC_IDX_W-1:0]  run_head  = '0;
    logic [SEC_IDX_W-1:0]  top_dirty = '0;

    t_idle idle_mode    = IDLE_NONE;
    int    fail_cnt     = 0;
    int    quiet_cycles = 0;

    always #6 i_clk = ~i_clk;

    function automatic bit roll(input int pct);
        return $urandom_range(0, 99) < pct;
    endfunction

    function automatic int src_idle_pct();
        case (idle_mode)
            IDLE_SRC:  return 72;
            IDLE_BOTH: return 8;
            default:   return 0;
        endcase
    endfunction

    function automatic int sink_stall_pct();
        case (idle_mode)
            IDLE_SINK: return 72;
            IDLE_BOTH: return 8;
            default:   return 0;
        endcase
    endfunction

    // Block size in force, clamped to the supported span.
    function automatic logic [CFG_DATA_W-1:0] eff_sectors();
        if (spb_reg < MIN_SECTORS) return CFG_DATA_W'(MIN_SECTORS);
        if (spb_reg > MAX_SECTORS_DEF) return CFG_DATA_W'(MAX_SECTORS_DEF);
        return spb_reg;
    endfunction

    function automatic t_range make_range(input logic [START_W-1:0] base,
                                          input logic [SEC_IDX_W-1:0] first,
                                          input logic [CFG_DATA_W-1:0] count);
        t_range r;
        r.start  = START_W'(64'(base) + (64'(first) << SECTOR_SHIFT));
        r.length = LEN_W'(64'(count) << SECTOR_SHIFT);
        r.last   = 1'b0;
        return r;
    endfunction

    // Walks the bits of one accepted word and queues the ranges it closes.
    task automatic predict_dirty_ranges(input logic [IDX_FIELD_W-1:0] idx,
                                        input logic [BYTE_W-1:0] bits);
        logic [CFG_DATA_W-1:0] spb;
        logic [START_W-1:0]    base;
        t_range                found[$];
        spb  = eff_sectors();
        base = START_W'(((64'(idx) & IDX_MASK) * 64'(spb)) << SECTOR_SHIFT);
        for (int b = 0; b < LANES; b++) begin
            if (sec_seen < spb) begin
                if (bits[b]) begin
                    top_dirty = sec_seen[SEC_IDX_W-1:0];
                    if (!run_open) begin
                        run_open = 1'b1;
                        run_head = sec_seen[SEC_IDX_W-1:0];
                    end
                end else if (run_open) begin
                    // Closed runs only come out in exact mode.
                    if (!rough_reg && found.size() < MAX_RANGES) begin
                        found.insert(found.size(), make_range(base, run_head,
                                     sec_seen - CFG_DATA_W'(run_head)));
                    end
                    run_open = 1'b0;
                end
                sec_seen = sec_seen + 1'b1;
            end
        end
        // At block end the mode in force decides what is flushed.
        if (sec_seen >= spb) begin
            if (rough_reg) begin
                if (found.size() < MAX_RANGES) begin
                    found.insert(found.size(),
                                 make_range(base, '0, CFG_DATA_W'(top_dirty) + 1'b1));
                end
            end else if (run_open && found.size() < MAX_RANGES) begin
                found.insert(found.size(),
                             make_range(base, run_head, sec_seen - CFG_DATA_W'(run_head)));
            end
            sec_seen  = '0;
            run_open  = 1'b0;
            run_head  = '0;
            top_dirty = '0;
        end
        if (found.size() != 0) found[found.size() - 1].last = 1'b1;
        foreach (found[k]) dirty_ranges_q.insert(dirty_ranges_q.size(), found[k]);
    endtask

    task automatic report_mismatch(input string field, input logic [63:0] want,
                                   input logic [63:0] got);
        fail_cnt++;
        $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
    endtask

    // Item driver: holds a word until it is taken, then loads the next one or idles.
    always @(posedge i_clk) begin
        t_bitmap_word w;
        if (!i_rst_n) begin
            item_ch.valid <= 1'b0;
        end else begin
            if (item_ch.valid && item_ch.ready) begin
                predict_dirty_ranges(item_ch.block_index, item_ch.bitmap_byte);
            end
            if (!item_ch.valid || item_ch.ready) begin
                if (bitmap_words_q.size() != 0 && !roll(src_idle_pct())) begin
                    w = bitmap_words_q.pop_front();
                    item_ch.valid       <= 1'b1;
                    item_ch.block_index <= w.block_index;
                    item_ch.bitmap_byte <= w.bits;
                end else begin
                    item_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Range monitor: checks each taken word against the oldest expected range.
    always @(posedge i_clk) begin
        t_range want;
        if (!i_rst_n) begin
            range_ch.ready <= 1'b0;
        end else begin
            if (range_ch.valid && range_ch.ready) begin
                if (dirty_ranges_q.size() == 0) begin
                    fail_cnt++;
                    $display("%0t: unexpected range, expected none, actual start 0x%0h "
                             , $time, range_ch.range_start,
                             "length 0x%0h last %0b", range_ch.range_length,
                             range_ch.last_range);
                end else begin
                    want = dirty_ranges_q.pop_front();
                    if (range_ch.range_start !== want.start) begin
                        report_mismatch("range_start", 64'(want.start), 64'(range_ch.range_start));
                    end
                    if (range_ch.range_length !== want.length) begin
                        report_mismatch("range_length", 64'(want.length),
                                        64'(range_ch.range_length));
                    end
                    if (range_ch.last_range !== want.last) begin
                        report_mismatch("last_range", 64'(want.last), 64'(range_ch.last_range));
                    end
                end
            end
            range_ch.ready <= !roll(sink_stall_pct());
        end
    end

    // Watchdog: ends the run when no word moves on either channel for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (item_ch.valid && item_ch.ready) || (range_ch.valid && range_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("[sector_bitmap_dirty_ranges_core] ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Waits until every word is taken and every range is out, then lets the pipe drain.
    task automatic wait_idle();
        @(negedge i_clk);
        while (bitmap_words_q.size() != 0 || item_ch.valid || dirty_ranges_q.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        wait_idle();
        @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_SECTORS_PER_BLOCK: spb_reg = data;
            CFG_ROUGH_MODE:        rough_reg = data[0];
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    task automatic send(input logic [IDX_FIELD_W-1:0] idx, input logic [BYTE_W-1:0] bits);
        t_bitmap_word w;
        w.block_index = idx;
        w.bits        = bits;
        bitmap_words_q.insert(bitmap_words_q.size(), w);
    endtask

    function automatic logic [BYTE_W-1:0] pick_bits();
        case ($urandom_range(0, 6))
            0: return '0;
            1: return '1;
            2: return 8'hAA;
            3: return 8'h55;
            4: return BYTE_W'(1) << $urandom_range(0, 7);
            default: return BYTE_W'($urandom());
        endcase
    endfunction

    function automatic logic [IDX_FIELD_W-1:0] pick_idx();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            default: return IDX_FIELD_W'($urandom());
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_spb();
        case ($urandom_range(0, 9))
            0: return CFG_DATA_W'($urandom_range(0, MIN_SECTORS - 1));
            1: return CFG_DATA_W'(MIN_SECTORS);
            2: return CFG_DATA_W'($urandom_range(49, 200));
            default: return CFG_DATA_W'($urandom_range(MIN_SECTORS + 1, 48));
        endcase
    endfunction

    initial begin
        int                     queued;
        int                     words;
        int                     count;
        int                     kind;
        logic [IDX_FIELD_W-1:0] idx;

        item_ch.valid       = 1'b0;
        item_ch.block_index = '0;
        item_ch.bitmap_byte = '0;
        range_ch.ready      = 1'b0;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Full-size block at reset settings: runs across word edges, up to four runs in a word.
        send('1, 8'hFF);
        send('1, 8'h00);
        send('1, 8'hAA);
        send('1, 8'h55);
        send('1, 8'h81);
        send('1, 8'hFE);
        // Shrinking the block below the sectors seen ends it on the next word.
        set_reg(CFG_SECTORS_PER_BLOCK, CFG_DATA_W'(16));
        send('1, 8'h00);

        // Sizes below the minimum act as the minimum; one word is one block.
        set_reg(CFG_SECTORS_PER_BLOCK, '0);
        send(IDX_FIELD_W'(1), 8'hAA);
        send(IDX_FIELD_W'(2), 8'h55);
        send(IDX_FIELD_W'(3), 8'h00);
        send(IDX_FIELD_W'(4), 8'hFF);

        // Size that is not a multiple of eight: the tail bits of the last word are dropped.
        set_reg(CFG_SECTORS_PER_BLOCK, CFG_DATA_W'(13));
        send(IDX_FIELD_W'(20'h5A5A5), 8'hFF);
        send(IDX_FIELD_W'(20'h5A5A5), 8'hFF);

        // Rough mode, including an empty bitmap.
        set_reg(CFG_ROUGH_MODE, CFG_DATA_W'(1));
        set_reg(CFG_SECTORS_PER_BLOCK, CFG_DATA_W'(MIN_SECTORS));
        send(IDX_FIELD_W'(20'hA5A5A), 8'h00);
        send(IDX_FIELD_W'(20'hA5A5A), 8'h80);
        send(IDX_FIELD_W'(20'hA5A5A), 8'h01);

        // Mode switched in the middle of a block, both ways.
        set_reg(CFG_SECTORS_PER_BLOCK, CFG_DATA_W'(16));
        set_reg(CFG_ROUGH_MODE, '0);
        send(IDX_FIELD_W'(7), 8'h0F);
        set_reg(CFG_ROUGH_MODE, CFG_DATA_W'(1));
        send(IDX_FIELD_W'(7), 8'h3C);
        send(IDX_FIELD_W'(8), 8'hF0);
        set_reg(CFG_ROUGH_MODE, '0);
        send(IDX_FIELD_W'(8), 8'h01);

        // Writes to indexes past the register list change nothing.
        set_reg(CFG_SPARE_LO, '1);
        set_reg(CFG_SPARE_HI, CFG_DATA_W'(1));
        send(IDX_FIELD_W'(9), 8'h81);
        send(IDX_FIELD_W'(9), 8'h00);

        // One full block at the largest size, given as an oversized value; it turns
        // rough near its end so the flush covers every sector.
        idle_mode = IDLE_BOTH;
        set_reg(CFG_SECTORS_PER_BLOCK, SPB_ABOVE_MAX);
        idx = pick_idx();
        for (int k = 0; k < BIG_EXACT; k++) send(idx, pick_bits());
        set_reg(CFG_ROUGH_MODE, CFG_DATA_W'(1));
        for (int k = 0; k < BIG_ROUGH - 1; k++) send(idx, pick_bits());
        send(idx, 8'h80);

        // Random phases: mostly whole blocks with one index, some cut short or with
        // a changing index. A block left open carries over into the next settings.
        for (int p = 0; p < PHASES; p++) begin
            idle_mode = t_idle'(p % 4);
            set_reg(CFG_SECTORS_PER_BLOCK, pick_spb());
            if (p < 2 || $urandom_range(0, 1) == 1) begin
                set_reg(CFG_ROUGH_MODE, CFG_DATA_W'($urandom()));
            end
            if ($urandom_range(0, 3) == 0) begin
                set_reg(CFG_SPARE_HI, CFG_DATA_W'($urandom()));
            end
            words  = (int'(eff_sectors()) + LANES - 1) / LANES;
            queued = 0;
            while (queued < PHASE_WORDS) begin
                kind  = $urandom_range(0, 9);
                count = (kind == 0) ? $urandom_range(1, words) : words;
                idx   = pick_idx();
                for (int k = 0; k < count; k++) begin
                    send((kind == 1) ? IDX_FIELD_W'($urandom()) : idx, pick_bits());
                end
                queued += count;
            end
        end

        wait_idle();
        if (fail_cnt == 0 && dirty_ranges_q.size() == 0) begin
            $display("[sector_bitmap_dirty_ranges_core] OK");
        end else begin
            $display("[sector_bitmap_dirty_ranges_core] ERROR");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
design/sbdr_pkg.sv
design/sbdr_item_if.sv
design/sbdr_range_if.sv
design/sbdr_lane.sv
design/sbdr_merge.sv
design/sbdr_emit.sv
design/sector_bitmap_dirty_ranges_core.sv
dv/tb_top.sv
